@@ hdl/kway_run_merger_assert.svh @@
// Assertion macros for the k-way run merger.
`ifndef KWAY_RUN_MERGER_ASSERT_SVH
`define KWAY_RUN_MERGER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define KWM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define KWM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KWM_ASSERT_IMP(lbl, ante, cons, msg)
`define KWM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/kwm_pkg.sv @@
// Shared constants and types for the k-way run merger.
`timescale 1ns / 1ps
package kwm_pkg;
	localparam int WAYS        = 8;
	localparam int IDX_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS);
	localparam int KEY_W       = 32;
	localparam int ID_W        = 32;
	localparam int WAY_FW      = 3;
	localparam int IN_DATA_W   = 72;
	localparam int OUT_DATA_W  = 72;
	localparam int IN_PAD_W    = IN_DATA_W - (WAY_FW + KEY_W + ID_W);
	localparam int OUT_PAD_W   = OUT_DATA_W - (KEY_W + ID_W + WAY_FW);

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_EMPTY  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_LOAD
	} state_t;

	// candidate travelling down the cell chain
	typedef struct packed {
		logic                    tok;
		logic                    found;
		logic                    fin;
		logic signed [KEY_W-1:0] key;
		logic [ID_W-1:0]         id;
		logic [IDX_W-1:0]        way;
	} cand_t;

	// broadcast command to every cell
	typedef struct packed {
		logic                    wr;
		logic                    empty;
		logic [IDX_W-1:0]        wr_way;
		logic signed [KEY_W-1:0] key;
		logic [ID_W-1:0]         id;
		logic                    fin;
		logic                    pop;
		logic [IDX_W-1:0]        pop_way;
		logic                    pop_fin;
		logic                    clr_done;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic done;
	} stat_t;
endpackage

@@ hdl/kwm_cell.sv @@
// One merge cell: head record of one way plus one stage of the min chain.
`timescale 1ns / 1ps
module kwm_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [kwm_pkg::IDX_W-1:0] idx,
	input  kwm_pkg::cmd_t           cmd,
	input  kwm_pkg::cand_t          chain_in,
	output kwm_pkg::cand_t          chain_out,
	output kwm_pkg::stat_t          stat
);
	import kwm_pkg::*;

	logic                    valid_q;
	logic                    done_q;
	logic                    fin_q;
	logic signed [KEY_W-1:0] key_q;
	logic [ID_W-1:0]         id_q;
	logic                    hit_wr;
	logic                    hit_pop;
	logic                    take_own;
	cand_t                   chain_s1;

	assign hit_wr  = cmd.wr && (cmd.wr_way == idx) && !valid_q && !done_q;
	assign hit_pop = cmd.pop && (cmd.pop_way == idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			if (hit_wr && cmd.empty == ACT_RECORD) begin
				valid_q <= 1'b1;
				fin_q   <= cmd.fin;
			end
			if (hit_pop)
				valid_q <= 1'b0;
			if (cmd.clr_done)
				done_q <= 1'b0;
			else if ((hit_wr && cmd.empty == ACT_EMPTY) || (hit_pop && cmd.pop_fin))
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_wr && cmd.empty == ACT_RECORD) begin
			key_q <= cmd.key;
			id_q  <= cmd.id;
		end
	end

	// strict less keeps the lower way on a tie
	assign take_own = valid_q && (!chain_in.found || (key_q < chain_in.key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_s1 <= '0;
		end else begin
			chain_s1.tok <= chain_in.tok;
			if (take_own) begin
				chain_s1.found <= 1'b1;
				chain_s1.fin   <= fin_q;
				chain_s1.key   <= key_q;
				chain_s1.id    <= id_q;
				chain_s1.way   <= idx;
			end else begin
				chain_s1.found <= chain_in.found;
				chain_s1.fin   <= chain_in.fin;
				chain_s1.key   <= chain_in.key;
				chain_s1.id    <= chain_in.id;
				chain_s1.way   <= chain_in.way;
			end
		end
	end

	assign chain_out  = chain_s1;
	assign stat.valid = valid_q;
	assign stat.done  = done_q;
endmodule

@@ hdl/kway_run_merger.sv @@
// Top level of the k-way run merger: control, cell chain and output register.
`timescale 1ns / 1ps
`include "kway_run_merger_assert.svh"
// Merges one ascending run per way into a single ascending run.
// Input stream (s_*): one item per record or per "way is empty" notice.
//   tuser = action (0 record, 1 empty), tlast = last record of the way.
// Output stream (m_*): one item per emitted record, smallest key first,
//   lowest way wins a tie. tuser[0] asks the source for its next record,
//   tuser[1] closes the merged run, tlast marks the final item that the
//   current input caused (at most MAX_RESULTS per input).
// Each way's head sits in a cell; the cells form a chain and a search token
// walks through them, one cell per cycle, keeping the best head so far.
// One input is worked on at a time; the next is taken once the last result
// of the previous one sits in the output register, even if not yet taken.
// A stalled receiver holds the output register and the block waits in the
// load state. Reset clears head valid and done flags; no clearing pass.
module kway_run_merger (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [2:0] way, [34:3] key, [66:35] record_id, [71:67] zero
	input  logic [kwm_pkg::IN_DATA_W-1:0]   s_tdata,
	// [0] action
	input  logic                            s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [31:0] out_key, [63:32] out_id, [66:64] source_way, [71:67] zero
	output logic [kwm_pkg::OUT_DATA_W-1:0]  m_tdata,
	// [0] refill_request, [1] run_complete
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast
);
	import kwm_pkg::*;

	state_t               state_q, state_d;
	cmd_t                 cmd;
	cand_t                chain [WAYS+1];
	stat_t                stat [WAYS];
	logic [WAYS-1:0]      valid_vec, done_vec, tok_vec, pop_dec;
	logic                 all_ready, any_valid, run_done, res_last;
	logic                 s_fire, way_ok, launch, load_fire, out_free;
	logic [WAY_FW-1:0]    in_way;
	logic [CNT_W-1:0]     cnt_q;
	cand_t                best_q;
	logic                 m_tvalid_q, m_tlast_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]           m_tuser_q;

	assign in_way = s_tdata[WAY_FW-1:0];
	assign way_ok = (32'(in_way) < 32'(WAYS));
	assign s_fire = s_tvalid && s_tready;

	// status of all cells
	genvar gi;
	generate
		for (gi = 0; gi < WAYS; gi++) begin : g_cell
			kwm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.idx       (IDX_W'(gi)),
				.cmd       (cmd),
				.chain_in  (chain[gi]),
				.chain_out (chain[gi+1]),
				.stat      (stat[gi])
			);
			assign valid_vec[gi] = stat[gi].valid;
			assign done_vec[gi]  = stat[gi].done;
			assign tok_vec[gi]   = chain[gi+1].tok;
		end
	endgenerate

	assign all_ready = &(valid_vec | done_vec);
	assign any_valid = |valid_vec;

	// head of chain: fresh token, nothing found yet
	assign chain[0] = {launch, {($bits(cand_t) - 1){1'b0}}};

	assign pop_dec  = WAYS'(1) << best_q.way;
	assign run_done = best_q.fin && (&(done_vec | pop_dec));
	assign res_last = !best_q.fin || run_done || (cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd          = '0;
		cmd.wr       = s_fire && way_ok;
		cmd.empty    = s_tuser;
		cmd.wr_way   = IDX_W'(in_way);
		cmd.key      = s_tdata[WAY_FW+KEY_W-1:WAY_FW];
		cmd.id       = s_tdata[WAY_FW+KEY_W+ID_W-1:WAY_FW+KEY_W];
		cmd.fin      = s_tlast;
		cmd.pop      = load_fire;
		cmd.pop_way  = best_q.way;
		cmd.pop_fin  = best_q.fin;
		// empty run, or the record just emitted closes the run
		cmd.clr_done = (state_q == ST_CHECK && all_ready && !any_valid)
			|| (load_fire && run_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		launch    = 1'b0;
		load_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (all_ready && any_valid) begin
					launch  = 1'b1;
					state_d = ST_SEARCH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SEARCH: begin
				if (chain[WAYS].tok)
					state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free) begin
					load_fire = 1'b1;
					state_d   = res_last ? ST_IDLE : ST_CHECK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// results emitted for the current input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (s_fire)
			cnt_q <= '0;
		else if (load_fire)
			cnt_q <= cnt_q + 1'b1;
	end

	// winner captured at the chain tail
	always_ff @(posedge clk) begin
		if (state_q == ST_SEARCH && chain[WAYS].tok)
			best_q <= chain[WAYS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (load_fire)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_fire) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, WAY_FW'(best_q.way), best_q.id, best_q.key};
			m_tuser_q <= {run_done, !best_q.fin};
			m_tlast_q <= res_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`KWM_ASSERT_IMP(a_tok_single, 1'b1, $onehot0(tok_vec), "more than one search token in chain")
	`KWM_ASSERT_IMP(a_flag_last, m_tvalid && (m_tuser[0] || m_tuser[1]), m_tlast, "refill or run end without last")
	`KWM_ASSERT_NXT(a_pop_clears, load_fire, !valid_vec[best_q.way], "emitted head still valid")
endmodule

@@ sim/kway_run_merger_check.sv @@
// Checker for the k-way run merger: tracks way heads, predicts merged items and compares.
`timescale 1ns / 1ps
module kway_run_merger_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [kwm_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	input  logic                           s_tlast,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [kwm_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [1:0]                     m_tuser,
	input  logic                           m_tlast,
	output int                             fail_count,
	output int                             pending
);
	import kwm_pkg::*;

	// keeps the log readable if the block goes badly wrong
	localparam int REPORT_CAP = 200;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [ID_W-1:0]         id;
		logic [WAY_FW-1:0]       way;
		logic                    refill;
		logic                    done;
		logic                    last;
	} merged_rec_t;

	merged_rec_t             merged_due [$];
	logic signed [KEY_W-1:0] head_key [WAYS];
	logic [ID_W-1:0]         head_id [WAYS];
	logic [WAYS-1:0]         head_ok;
	logic [WAYS-1:0]         head_fin;
	logic [WAYS-1:0]         way_done;

	task automatic report_diff(input string what, input logic [31:0] want,
			input logic [31:0] got);
		fail_count++;
		if (fail_count <= REPORT_CAP)
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
	endtask

	// one input item: load a head or retire an empty way, then emit while all ways are settled
	task automatic merge_predict(input logic act, input logic [WAY_FW-1:0] w,
			input logic signed [KEY_W-1:0] k, input logic [ID_W-1:0] id, input logic fin);
		merged_rec_t batch [MAX_RESULTS];
		int          n;
		int          best;
		int          i;
		bit          stop;
		n = 0;
		stop = 1'b0;
		if (int'(w) < WAYS && !head_ok[w] && !way_done[w]) begin
			if (act == ACT_RECORD) begin
				head_key[w] = k;
				head_id[w]  = id;
				head_fin[w] = fin;
				head_ok[w]  = 1'b1;
			end else begin
				way_done[w] = 1'b1;
			end
		end
		while (!stop && n < MAX_RESULTS && &(head_ok | way_done)) begin
			if (!(|head_ok)) begin
				// every way finished with nothing held: new run, nothing emitted
				way_done = '0;
				stop = 1'b1;
			end else begin
				best = -1;
				for (i = 0; i < WAYS; i++)
					if (head_ok[i] && (best < 0 || head_key[i] < head_key[best]))
						best = i;
				batch[n]     = '0;
				batch[n].key = head_key[best];
				batch[n].id  = head_id[best];
				batch[n].way = WAY_FW'(best);
				head_ok[best] = 1'b0;
				if (!head_fin[best]) begin
					batch[n].refill = 1'b1;
					stop = 1'b1;
				end else begin
					way_done[best] = 1'b1;
					if (&way_done) begin
						batch[n].done = 1'b1;
						way_done = '0;
						stop = 1'b1;
					end
				end
				n++;
			end
		end
		for (i = 0; i < n; i++) begin
			batch[i].last = (i == n - 1);
			merged_due.push_back(batch[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		merged_rec_t want;
		int          i;
		if (!arst_n) begin
			merged_due.delete();
			head_ok  = '0;
			head_fin = '0;
			way_done = '0;
			for (i = 0; i < WAYS; i++) begin
				head_key[i] = '0;
				head_id[i]  = '0;
			end
			fail_count = 0;
			pending    = 0;
		end else begin
			// outputs first: an item taken on this edge cannot have caused them
			if (m_tvalid && m_tready) begin
				if (merged_due.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_CAP)
						$display("%0t: item expected none, got tdata %0h tuser %b tlast %b",
							$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = merged_due.pop_front();
					if (m_tdata[0 +: KEY_W] !== want.key)
						report_diff("out_key", want.key, m_tdata[0 +: KEY_W]);
					if (m_tdata[KEY_W +: ID_W] !== want.id)
						report_diff("out_id", want.id, m_tdata[KEY_W +: ID_W]);
					if (m_tdata[KEY_W+ID_W +: WAY_FW] !== want.way)
						report_diff("source_way", 32'(want.way),
							32'(m_tdata[KEY_W+ID_W +: WAY_FW]));
					if (m_tdata[KEY_W+ID_W+WAY_FW +: OUT_PAD_W] !== '0)
						report_diff("tdata padding", 32'd0,
							32'(m_tdata[KEY_W+ID_W+WAY_FW +: OUT_PAD_W]));
					if (m_tuser[0] !== want.refill)
						report_diff("refill_request", 32'(want.refill), 32'(m_tuser[0]));
					if (m_tuser[1] !== want.done)
						report_diff("run_complete", 32'(want.done), 32'(m_tuser[1]));
					if (m_tlast !== want.last)
						report_diff("last", 32'(want.last), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				merge_predict(s_tuser, s_tdata[0 +: WAY_FW], s_tdata[WAY_FW +: KEY_W],
					s_tdata[WAY_FW+KEY_W +: ID_W], s_tlast);
			pending = merged_due.size();
		end
	end
endmodule

@@ sim/kway_run_merger_test.sv @@
// Testbench top for the k-way run merger: builds run traffic, paces both sides, gives the verdict.
`timescale 1ns / 1ps
module kway_run_merger_test;
	import kwm_pkg::*;

	localparam int RANDOM_ITEMS = 195;
	localparam int MAX_REC      = 4;     // records per way in a random run
	localparam int IDLE_PCT     = 26;
	// receiver pacing, in cycles after reset
	localparam int RX_CALM_LO   = 500;
	localparam int RX_CALM_HI   = 900;
	localparam int HOLD_AT      = 1300;
	localparam int HOLD_LEN     = 300;
	// extra wait after the drain; at most MAX_RESULTS results per item
	localparam int TAIL         = 2 * MAX_RESULTS * (WAYS + 2);

	// all eight ways hold one final head: extremes and ties in one burst
	localparam logic [KEY_W-1:0] CORNER_KEY [WAYS] = '{
		32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
		32'h0000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000};
	localparam logic [ID_W-1:0] CORNER_ID [WAYS] = '{
		32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
		32'h7fff_ffff, 32'haaaa_5555, 32'h5555_aaaa, 32'hffff_ffff};

	typedef struct packed {
		logic                    act;
		logic [WAY_FW-1:0]       way;
		logic signed [KEY_W-1:0] key;
		logic [ID_W-1:0]         id;
		logic                    fin;
	} feed_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	int                    errors;
	int                    waiting;

	feed_item_t feed [$];

	kway_run_merger dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	kway_run_merger_check merge_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (errors),
		.pending    (waiting)
	);

	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic push_item(input logic act, input int way, input logic [KEY_W-1:0] key,
			input logic [ID_W-1:0] id, input logic fin);
		feed_item_t it;
		it.act = act;
		it.way = WAY_FW'(way);
		it.key = key;
		it.id  = id;
		it.fin = fin;
		feed.push_back(it);
	endtask

	// planned item, now and then dropped or followed by a stray item
	task automatic push_planned(input logic act, input int way, input logic [KEY_W-1:0] key,
			input logic [ID_W-1:0] id, input logic fin);
		if ($urandom_range(99) >= 1)
			push_item(act, way, key, id, fin);
		if ($urandom_range(99) < 5)
			push_item(1'($urandom_range(1)), int'($urandom_range(WAYS - 1)), $urandom,
				$urandom, 1'($urandom_range(1)));
	endtask

	// extremes, a tight band round zero for ties, otherwise anything
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 32'h8000_0000;
		if (r < 16)
			return 32'h7fff_ffff;
		if (r < 46)
			return 32'($urandom_range(8)) - 32'd4;
		return $urandom;
	endfunction

	// One run: first heads in shuffled way order, then refills in the order the merge
	// asks for them. Unordered runs still follow the block's head-by-head choice.
	task automatic add_run(input int max_len, input bit in_order);
		int                      len [WAYS];
		int                      hd [WAYS];
		int                      ord [WAYS];
		logic signed [KEY_W-1:0] rk [WAYS][MAX_REC];
		logic [ID_W-1:0]         rid [WAYS][MAX_REC];
		logic signed [KEY_W-1:0] tmp;
		int                      w;
		int                      j;
		int                      t;
		int                      best;
		bit                      more;
		for (w = 0; w < WAYS; w++) begin
			len[w] = ($urandom_range(99) < 12) ? 0 : $urandom_range(max_len, 1);
			for (j = 0; j < len[w]; j++) begin
				rk[w][j]  = pick_key();
				rid[w][j] = $urandom;
			end
			if (in_order)
				for (j = 1; j < len[w]; j++)
					for (t = j; t > 0 && rk[w][t] < rk[w][t-1]; t--) begin
						tmp         = rk[w][t];
						rk[w][t]    = rk[w][t-1];
						rk[w][t-1]  = tmp;
					end
			hd[w]  = 0;
			ord[w] = w;
		end
		for (w = WAYS - 1; w > 0; w--) begin
			j      = $urandom_range(w);
			t      = ord[w];
			ord[w] = ord[j];
			ord[j] = t;
		end
		for (t = 0; t < WAYS; t++) begin
			w = ord[t];
			if (len[w] == 0)
				push_planned(ACT_EMPTY, w, $urandom, $urandom, 1'($urandom_range(1)));
			else
				push_planned(ACT_RECORD, w, rk[w][0], rid[w][0], len[w] == 1);
		end
		more = 1'b1;
		while (more) begin
			best = -1;
			for (w = 0; w < WAYS; w++)
				if (hd[w] < len[w] && (best < 0 || rk[w][hd[w]] < rk[best][hd[best]]))
					best = w;
			if (best < 0) begin
				more = 1'b0;
			end else begin
				hd[best]++;
				if (hd[best] < len[best])
					push_planned(ACT_RECORD, best, rk[best][hd[best]], rid[best][hd[best]],
						hd[best] == len[best] - 1);
			end
		end
	endtask

	// receiver: random back-pressure, one calm window and one long hold-off
	initial begin
		int cyc;
		int hold;
		m_tready <= 1'b0;
		cyc  = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == HOLD_AT)
				hold = HOLD_LEN;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (cyc >= RX_CALM_LO && cyc < RX_CALM_HI) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// sender and verdict
	initial begin
		int i;
		int w;
		int n_directed;
		int pause_a;
		int pause_b;
		bit quiet;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		s_tlast  <= 1'b0;

		// eight final heads at the key extremes with ties: one burst closing the run
		for (w = WAYS - 1; w >= 0; w--)
			push_item(ACT_RECORD, w, CORNER_KEY[w], CORNER_ID[w], 1'b1);
		// a record and a notice aimed at a way that already holds a head are dropped
		push_item(ACT_RECORD, 3, -32'sd5, 32'h0000_0003, 1'b0);
		push_item(ACT_RECORD, 3, 32'h7fff_ffff, 32'h0000_dead, 1'b1);
		push_item(ACT_EMPTY, 3, 32'h0, 32'h0, 1'b0);
		for (w = 0; w < WAYS; w++)
			if (w != 3)
				push_item(ACT_EMPTY, w, 32'h0, 32'h0, 1'b0);
		// refill answered by a notice: every way done with nothing held
		push_item(ACT_EMPTY, 3, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		// a run with no records at all
		for (w = 0; w < WAYS; w++)
			push_item(ACT_EMPTY, w, 32'h0, 32'h0, 1'b1);
		n_directed = feed.size();

		while (feed.size() < n_directed + RANDOM_ITEMS)
			add_run(($urandom_range(9) == 0) ? 1 : MAX_REC, $urandom_range(9) != 0);
		pause_a = n_directed;
		pause_b = n_directed + (feed.size() - n_directed) / 2;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < feed.size(); i++) begin
			quiet = (i >= n_directed + 100) && (i < n_directed + 150);
			// drain point: hold back until every predicted item has come out
			while (((i == pause_a || i == pause_b) && waiting != 0)
					|| (!quiet && $urandom_range(99) < IDLE_PCT)) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= {{IN_PAD_W{1'b0}}, feed[i].id, feed[i].key, feed[i].way};
			s_tuser  <= feed[i].act;
			s_tlast  <= feed[i].fin;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			@(negedge clk);
		end
		s_tvalid <= 1'b0;

		while (waiting != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);

		if (waiting != 0)
			$display("%0t: %0d predicted items never came out", $time, waiting);
		if (errors == 0 && waiting == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
